// ----- sv/midi_note_sustain_tracker_core_assert.svh -----
// Assertion macros shared by the note tracker checker.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef MIDI_NOTE_SUSTAIN_TRACKER_CORE_ASSERT_SVH
`define MIDI_NOTE_SUSTAIN_TRACKER_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define MNST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define MNST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/mnst_pkg.sv -----
// Shared types and constants for the MIDI note sustain tracker.
// No dependencies; imported by every RTL module of the block but mnst_ram.
package mnst_pkg;

  // Note range and channel bitmap width
  localparam int NOTE_COUNT   = 128;
  localparam int CHANNEL_BITS = 16;

  localparam int HalfNotes = 64;
  localparam int HalfW     = $clog2(HalfNotes);
  localparam int RowDepth  = 2 * 128;
  localparam int RowAddrW  = $clog2(RowDepth);
  localparam int RowW      = 2 * CHANNEL_BITS;
  localparam int PedalCnt  = 32;

  localparam logic [7:0] NoteLimit = 8'(NOTE_COUNT);
  localparam logic [5:0] ChanLimit = 6'(CHANNEL_BITS);

  // Item modes
  localparam logic [1:0] ModeNoteOn  = 2'd0;
  localparam logic [1:0] ModeNoteOff = 2'd1;
  localparam logic [1:0] ModeSustain = 2'd2;
  localparam logic [1:0] ModeFree    = 2'd3;

  // Event kinds
  localparam logic EvOn  = 1'b0;
  localparam logic EvOff = 1'b1;

  typedef enum logic [1:0] {
    OutSelOff  = 2'd0,
    OutSelOn   = 2'd1,
    OutSelPend = 2'd2
  } out_sel_e;

  typedef struct packed {
    logic [1:0] mode;
    logic       layer;
    logic [3:0] channel;
    logic [6:0] note;
    logic [6:0] velocity;
    logic       pedal_down;
  } in_t;

  typedef struct packed {
    logic       event_kind;
    logic [3:0] out_channel;
    logic [6:0] out_note;
    logic [6:0] out_velocity;
    logic       last;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load_item;
    logic     rd_single;
    logic     rd_drain;
    logic     wr_single;
    logic     wr_drain;
    logic     set_flag;
    logic     push;
    out_sel_e out_sel;
    logic     out_last;
    logic     pend_load;
    logic     pend_clr;
    logic     cnt_clr;
    logic     cnt_inc;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] mode;
    logic       pedal_down;
    logic       chan_ok;
    logic       note_ok;
    logic       act;
    logic       hld;
    logic       flag;
    logic       slot;
    logic       cnt_last;
    logic       dnote_ok;
    logic       pend_v;
  } sts_t;

endpackage

// ----- sv/mnst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mnst_ram #(
  parameter int Width = 32,
  parameter int Depth = 256,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/mnst_ctrl.sv -----
// Sequencer of the note tracker: dispatches items, single-note updates and drain walks.
// Depends on mnst_pkg for command and status types.
module mnst_ctrl import mnst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SDisp = 3'd1;
  localparam logic [2:0] SEval = 3'd2;
  localparam logic [2:0] SOn   = 3'd3;
  localparam logic [2:0] SDrd  = 3'd4;
  localparam logic [2:0] SDchk = 3'd5;
  localparam logic [2:0] SDend = 3'd6;

  logic [2:0] state_q, state_d;
  logic       hit;

  // Drain hit: free releases active notes, both release held notes
  assign hit = sts_i.dnote_ok &&
               (((sts_i.mode == ModeFree) && sts_i.act) || sts_i.hld);

  assign in_ready_o = (state_q == SIdle);

  // Next state and commands
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          cmd_o.cnt_clr   = 1'b1;
          state_d         = SDisp;
        end
      end
      SDisp: begin
        if (!sts_i.chan_ok) begin
          state_d = SIdle;
        end else begin
          case (sts_i.mode)
            ModeNoteOn, ModeNoteOff: begin
              if (sts_i.note_ok) begin
                cmd_o.rd_single = 1'b1;
                state_d         = SEval;
              end else begin
                state_d = SIdle;
              end
            end
            ModeSustain: begin
              cmd_o.set_flag = 1'b1;
              state_d        = sts_i.pedal_down ? SIdle : SDrd;
            end
            ModeFree: begin
              cmd_o.set_flag = 1'b1;
              state_d        = SDrd;
            end
            default: state_d = SIdle;
          endcase
        end
      end
      SEval: begin
        if (sts_i.mode == ModeNoteOn) begin
          // retrigger needs an off first
          if (!((sts_i.act || sts_i.hld) && !sts_i.slot)) begin
            cmd_o.wr_single = 1'b1;
            if (sts_i.act || sts_i.hld) begin
              cmd_o.push     = 1'b1;
              cmd_o.out_sel  = OutSelOff;
              cmd_o.out_last = 1'b0;
            end
            state_d = SOn;
          end
        end else if (!sts_i.act) begin
          state_d = SIdle;
        end else if (sts_i.flag) begin
          cmd_o.wr_single = 1'b1;
          state_d         = SIdle;
        end else if (sts_i.slot) begin
          cmd_o.wr_single = 1'b1;
          cmd_o.push      = 1'b1;
          cmd_o.out_sel   = OutSelOff;
          cmd_o.out_last  = 1'b1;
          state_d         = SIdle;
        end
      end
      SOn: begin
        if (sts_i.slot) begin
          cmd_o.push     = 1'b1;
          cmd_o.out_sel  = OutSelOn;
          cmd_o.out_last = 1'b1;
          state_d        = SIdle;
        end
      end
      SDrd: begin
        cmd_o.rd_drain = 1'b1;
        state_d        = SDchk;
      end
      SDchk: begin
        // hold while a pending off cannot be sent yet
        if (!(hit && sts_i.pend_v && !sts_i.slot)) begin
          if (hit) begin
            cmd_o.wr_drain  = 1'b1;
            cmd_o.pend_load = 1'b1;
            if (sts_i.pend_v) begin
              cmd_o.push     = 1'b1;
              cmd_o.out_sel  = OutSelPend;
              cmd_o.out_last = 1'b0;
            end
          end
          if (sts_i.cnt_last) begin
            state_d = SDend;
          end else begin
            cmd_o.cnt_inc = 1'b1;
            state_d       = SDrd;
          end
        end
      end
      SDend: begin
        if (!sts_i.pend_v) begin
          state_d = SIdle;
        end else if (sts_i.slot) begin
          cmd_o.push     = 1'b1;
          cmd_o.out_sel  = OutSelPend;
          cmd_o.out_last = 1'b1;
          cmd_o.pend_clr = 1'b1;
          state_d        = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/mnst_dp.sv -----
// Datapath of the note tracker: item register, bitmap RAM with row valid bits,
// pedal flags, drain counter, pending off and output register. Uses mnst_pkg, mnst_ram.
module mnst_dp import mnst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_data_i,
  input  logic cfg_valid_i,
  input  logic cfg_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o,
  input  cmd_t cmd_i,
  output sts_t sts_o
);

  in_t                     item_q;
  logic                    mute_q;
  logic [PedalCnt-1:0]     pedal_q;
  logic [RowDepth-1:0]     row_vld_q;
  logic                    vld_rd_q;
  logic [HalfW-1:0]        cnt_q;
  logic                    pend_v_q;
  logic [6:0]              pend_note_q;
  logic                    out_valid_q;
  out_t                    out_q;

  logic [6:0]              dnote;
  logic [RowAddrW-1:0]     item_addr, drain_addr, raddr, waddr;
  logic                    re, we;
  logic [RowW-1:0]         rdata, row, wdata;
  logic [CHANNEL_BITS-1:0] mask, act_row, hld_row, new_act, new_hld;
  logic [4:0]              pidx;
  logic                    flag, load_out;
  out_t                    out_d;

  // Addresses of the item note and of the current drain note
  assign dnote      = {item_q.note[6], cnt_q};
  assign item_addr  = {item_q.layer, item_q.note};
  assign drain_addr = {item_q.layer, dnote};
  assign raddr      = cmd_i.rd_drain ? drain_addr : item_addr;
  assign waddr      = cmd_i.wr_drain ? drain_addr : item_addr;
  assign re         = cmd_i.rd_single | cmd_i.rd_drain;
  assign we         = cmd_i.wr_single | cmd_i.wr_drain;

  mnst_ram #(
    .Width (RowW),
    .Depth (RowDepth)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Rows never written read as zero
  assign row     = vld_rd_q ? rdata : '0;
  assign act_row = row[CHANNEL_BITS-1:0];
  assign hld_row = row[RowW-1:CHANNEL_BITS];
  assign mask    = CHANNEL_BITS'(1) << item_q.channel;
  assign pidx    = {item_q.layer, item_q.channel};
  assign flag    = pedal_q[pidx];

  // Build the updated row
  always_comb begin
    new_act = act_row;
    new_hld = hld_row;
    if (cmd_i.wr_drain) begin
      if ((item_q.mode == ModeFree) && |(act_row & mask)) begin
        new_act = act_row & ~mask;
      end else begin
        new_hld = hld_row & ~mask;
      end
    end else if (item_q.mode == ModeNoteOn) begin
      new_act = act_row | mask;
      new_hld = hld_row & ~mask;
    end else begin
      new_act = act_row & ~mask;
      if (flag) begin
        new_hld = hld_row | mask;
      end
    end
  end

  assign wdata = {new_hld, new_act};

  // Select the event to send
  always_comb begin
    out_d.out_channel  = item_q.channel;
    out_d.last         = cmd_i.out_last;
    case (cmd_i.out_sel)
      OutSelOn: begin
        out_d.event_kind   = EvOn;
        out_d.out_note     = item_q.note;
        out_d.out_velocity = item_q.velocity;
      end
      OutSelPend: begin
        out_d.event_kind   = EvOff;
        out_d.out_note     = pend_note_q;
        out_d.out_velocity = '0;
      end
      default: begin
        out_d.event_kind   = EvOff;
        out_d.out_note     = item_q.note;
        out_d.out_velocity = '0;
      end
    endcase
  end

  assign load_out = cmd_i.push & ~mute_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mute_q      <= 1'b0;
      pedal_q     <= '0;
      row_vld_q   <= '0;
      vld_rd_q    <= 1'b0;
      cnt_q       <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mute_q <= cfg_data_i;
      end
      if (cmd_i.set_flag) begin
        pedal_q[pidx] <= (item_q.mode == ModeSustain) ? item_q.pedal_down : 1'b0;
      end
      if (we) begin
        row_vld_q[waddr] <= 1'b1;
      end
      if (re) begin
        vld_rd_q <= row_vld_q[raddr];
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + HalfW'(1);
      end
      if (cmd_i.pend_load) begin
        pend_v_q <= 1'b1;
      end else if (cmd_i.pend_clr) begin
        pend_v_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.pend_load) begin
      pend_note_q <= dnote;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  // Status back to the sequencer
  always_comb begin
    sts_o.mode       = item_q.mode;
    sts_o.pedal_down = item_q.pedal_down;
    sts_o.chan_ok    = {2'b00, item_q.channel} < ChanLimit;
    sts_o.note_ok    = {1'b0, item_q.note} < NoteLimit;
    sts_o.act        = |(act_row & mask);
    sts_o.hld        = |(hld_row & mask);
    sts_o.flag       = flag;
    sts_o.slot       = mute_q | ~out_valid_q | out_ready_i;
    sts_o.cnt_last   = &cnt_q;
    sts_o.dnote_ok   = {1'b0, dnote} < NoteLimit;
    sts_o.pend_v     = pend_v_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/midi_note_sustain_tracker_core.sv -----
// MIDI note tracker with sustain pedal, two layers. One item at a time.
// Note on: on event, with a retrigger off before it where the note still sounds or is held;
// note off: off event. Pedal release / channel free: for each note of the half, one bitmap
// RAM read, then the check and write-back; output stalls lengthen the walk.
// Async active-low reset clears bitmap row valid bits, pedal flags and the mute bit.
module midi_note_sustain_tracker_core import mnst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // Configuration is always taken
  assign cfg_ready_o = 1'b1;

  mnst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mnst_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ----- sv/mnst_checker.sv -----
// Port-level checks for the note tracker core, bound to the top level.
// Uses mnst_pkg and the assertion macro header.
`include "midi_note_sustain_tracker_core_assert.svh"

module mnst_checker import mnst_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o,
  input logic cfg_valid_i,
  input logic cfg_ready_o,
  input logic cfg_data_i
);

  // Hold a stalled result
  `MNST_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result dropped or changed while stalled")

  // One item at a time: no transfer right after a transfer
  `MNST_ASSERT(a_in_single, in_valid_i && in_ready_o |=> !in_ready_o, "input taken while an item is in work")

  // Note off events carry zero velocity
  `MNST_ASSERT(a_off_vel, out_valid_o && (out_data_o.event_kind == EvOff) |-> out_data_o.out_velocity == 7'd0, "note off with nonzero velocity")

  // No result after a reset edge
  `MNST_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule

bind midi_note_sustain_tracker_core mnst_checker u_mnst_checker (.*);

// ----- test/midi_note_sustain_tracker_core_checker.sv -----
`timescale 1ns / 100ps
// Event checker for the MIDI note sustain tracker: mirrors the note bitmaps,
// predicts the note on/off stream for every input transfer and compares it.
// Depends on mnst_pkg for the payload structs, modes and event kinds.
module midi_note_sustain_tracker_core_checker import mnst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  input  logic cfg_valid_i,
  input  logic cfg_ready_i,
  input  logic cfg_data_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int HalfSpan = 64;
  localparam int RowCount = 256;

  // Mirror of the block's bookkeeping
  logic [15:0] active_map [RowCount];
  logic [15:0] held_map [RowCount];
  logic        pedal_on [32];
  logic        mute_on;

  out_t note_event_q [$];
  int   fail_n;
  out_t got_ev;
  out_t want_ev;
  logic bad;
  logic show;

  function automatic out_t note_event(logic kind, logic [3:0] chan, logic [6:0] note,
                                      logic [6:0] vel);
    out_t ev;
    ev.event_kind   = kind;
    ev.out_channel  = chan;
    ev.out_note     = note;
    ev.out_velocity = vel;
    ev.last         = 1'b0;
    return ev;
  endfunction

  // Update the bitmaps for one item and queue the events it must produce
  task automatic track_item(input in_t item);
    out_t        evs [$];
    out_t        ev;
    logic [7:0]  row;
    logic [7:0]  drow;
    logic [4:0]  pidx;
    logic [15:0] chan_bit;
    logic [6:0]  dnote;
    row      = {item.layer, item.note};
    pidx     = {item.layer, item.channel};
    chan_bit = 16'(1) << item.channel;
    if (int'(item.channel) >= CHANNEL_BITS) return;
    case (item.mode)
      ModeNoteOn: begin
        if (int'(item.note) >= NOTE_COUNT) return;
        if (|(active_map[row] & chan_bit)) begin
          evs.push_back(note_event(EvOff, item.channel, item.note, 7'd0));
        end else if (|(held_map[row] & chan_bit)) begin
          held_map[row]   = held_map[row] & ~chan_bit;
          active_map[row] = active_map[row] | chan_bit;
          evs.push_back(note_event(EvOff, item.channel, item.note, 7'd0));
        end else begin
          active_map[row] = active_map[row] | chan_bit;
        end
        evs.push_back(note_event(EvOn, item.channel, item.note, item.velocity));
      end
      ModeNoteOff: begin
        if (int'(item.note) >= NOTE_COUNT || !(|(active_map[row] & chan_bit))) return;
        active_map[row] = active_map[row] & ~chan_bit;
        if (pedal_on[pidx]) held_map[row] = held_map[row] | chan_bit;
        else evs.push_back(note_event(EvOff, item.channel, item.note, 7'd0));
      end
      default: begin
        // Pedal release and channel free walk one half of the notes upward
        if (item.mode == ModeSustain) pedal_on[pidx] = item.pedal_down;
        else pedal_on[pidx] = 1'b0;
        if (item.mode == ModeFree || !item.pedal_down) begin
          for (int i = 0; i < HalfSpan; i++) begin
            dnote = {item.note[6], 6'(i)};
            drow  = {item.layer, dnote};
            if (int'(dnote) >= NOTE_COUNT) continue;
            if (item.mode == ModeFree && |(active_map[drow] & chan_bit)) begin
              active_map[drow] = active_map[drow] & ~chan_bit;
              evs.push_back(note_event(EvOff, item.channel, dnote, 7'd0));
            end else if (|(held_map[drow] & chan_bit)) begin
              held_map[drow] = held_map[drow] & ~chan_bit;
              evs.push_back(note_event(EvOff, item.channel, dnote, 7'd0));
            end
          end
        end
      end
    endcase
    // Mute drops the events but keeps the bookkeeping above
    if (mute_on || evs.size() == 0) return;
    ev      = evs.pop_back();
    ev.last = 1'b1;
    evs.push_back(ev);
    foreach (evs[k]) note_event_q.push_back(evs[k]);
  endtask

  // Follow every transfer on the three channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < RowCount; r++) begin
        active_map[r] = '0;
        held_map[r]   = '0;
      end
      for (int c = 0; c < 32; c++) pedal_on[c] = 1'b0;
      mute_on = 1'b0;
      note_event_q.delete();
      fail_n = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) mute_on = cfg_data_i;
      if (in_valid_i && in_ready_i) track_item(in_data_i);
      if (out_valid_i && out_ready_i) begin
        got_ev = out_data_i;
        show   = (fail_n < 40);
        if (note_event_q.size() == 0) begin
          if (show) $display("%0t: unexpected event %h", $time, got_ev);
          fail_n++;
        end else begin
          want_ev = note_event_q.pop_front();
          bad     = 1'b0;
          if (got_ev.event_kind !== want_ev.event_kind) begin
            if (show) $display("%0t: event_kind expected %0d got %0d", $time,
                               want_ev.event_kind, got_ev.event_kind);
            bad = 1'b1;
          end
          if (got_ev.out_channel !== want_ev.out_channel) begin
            if (show) $display("%0t: out_channel expected %0d got %0d", $time,
                               want_ev.out_channel, got_ev.out_channel);
            bad = 1'b1;
          end
          if (got_ev.out_note !== want_ev.out_note) begin
            if (show) $display("%0t: out_note expected %0d got %0d", $time,
                               want_ev.out_note, got_ev.out_note);
            bad = 1'b1;
          end
          if (got_ev.out_velocity !== want_ev.out_velocity) begin
            if (show) $display("%0t: out_velocity expected %0d got %0d", $time,
                               want_ev.out_velocity, got_ev.out_velocity);
            bad = 1'b1;
          end
          if (got_ev.last !== want_ev.last) begin
            if (show) $display("%0t: last expected %0d got %0d", $time,
                               want_ev.last, got_ev.last);
            bad = 1'b1;
          end
          if (bad) fail_n++;
        end
      end
      fail_count_o <= fail_n;
      pending_o    <= note_event_q.size();
    end
  end

endmodule

// ----- test/midi_note_sustain_tracker_core_test.sv -----
`timescale 1ns / 100ps
// Top of the note tracker testbench: clock, reset, stimulus, output stalls
// and verdict. Depends on mnst_pkg and midi_note_sustain_tracker_core_checker.
module midi_note_sustain_tracker_core_test;
  import mnst_pkg::*;

  localparam int CycleLimit  = 6_000_000;
  localparam int SettleTicks = 300;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_ready_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_data_i  = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;
  logic cfg_ready_o;
  int   fail_count;
  int   pending;

  int         cycle_n    = 0;
  int         stall_left = 0;
  int         calm_left  = 0;
  int         roll;
  logic       ready_next;
  logic       send_calm  = 1'b0;
  logic [3:0] chan_pool [4];
  logic [6:0] note_pool [8];
  int         phase_len [5] = '{60, 20, 50, 15, 40};
  logic       phase_mute [5] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

  midi_note_sustain_tracker_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  midi_note_sustain_tracker_core_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Pause length: mostly short, now and then long
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Stall the event sink at random, with calm stretches in between
  always @(posedge clk_i) begin
    ready_next = 1'b1;
    if (stall_left > 0) begin
      ready_next = 1'b0;
      stall_left = stall_left - 1;
    end else if (calm_left > 0) begin
      calm_left = calm_left - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        calm_left = $urandom_range(40, 200);
      end else if (roll < 18) begin
        ready_next = 1'b0;
        stall_left = pick_pause() - 1;
      end
    end
    out_ready_i <= ready_next;
  end

  function automatic in_t mk(logic [1:0] mode, logic layer, logic [3:0] chan,
                             logic [6:0] note, logic [6:0] vel, logic pedal);
    in_t item;
    item.mode       = mode;
    item.layer      = layer;
    item.channel    = chan;
    item.note       = note;
    item.velocity   = vel;
    item.pedal_down = pedal;
    return item;
  endfunction

  // Mostly reuse a few channels and notes so on, off and drains collide
  function automatic in_t random_item();
    in_t item;
    int  r;
    r = $urandom_range(0, 99);
    item.mode = (r < 40) ? ModeNoteOn : (r < 75) ? ModeNoteOff :
                (r < 90) ? ModeSustain : ModeFree;
    item.layer      = 1'($urandom_range(0, 1));
    item.channel    = ($urandom_range(0, 99) < 85) ? chan_pool[$urandom_range(0, 3)]
                                                   : 4'($urandom_range(0, 15));
    item.note       = ($urandom_range(0, 99) < 85) ? note_pool[$urandom_range(0, 7)]
                                                   : 7'($urandom_range(0, 127));
    item.velocity   = 7'($urandom_range(0, 127));
    item.pedal_down = 1'($urandom_range(0, 1));
    return item;
  endfunction

  task automatic refresh_pools();
    foreach (chan_pool[k]) chan_pool[k] = 4'($urandom_range(0, 15));
    foreach (note_pool[k]) note_pool[k] = 7'($urandom_range(0, 127));
    note_pool[6] = 7'd0;
    note_pool[7] = 7'd127;
  endtask

  // Offer one item and hold it until the transfer
  task automatic send_item(input in_t item);
    int gap;
    gap = (send_calm || $urandom_range(0, 99) < 55) ? 0 : pick_pause();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid, wait for every expected event, then let a silent drain finish
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  task automatic write_mute(input logic value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_mute(1'b0);

    // Fresh on, retrigger, plain off, then a stray off
    send_item(mk(ModeNoteOn,  1'b0, 4'd0,  7'd0,   7'd127, 1'b0));
    send_item(mk(ModeNoteOn,  1'b0, 4'd0,  7'd0,   7'd1,   1'b0));
    send_item(mk(ModeNoteOff, 1'b0, 4'd0,  7'd0,   7'd0,   1'b0));
    send_item(mk(ModeNoteOff, 1'b0, 4'd0,  7'd0,   7'd0,   1'b0));
    // Pedal held: offs park, a held note retriggers, release drains the upper half
    send_item(mk(ModeSustain, 1'b1, 4'd15, 7'd0,   7'd0,   1'b1));
    send_item(mk(ModeNoteOn,  1'b1, 4'd15, 7'd127, 7'd0,   1'b0));
    send_item(mk(ModeNoteOff, 1'b1, 4'd15, 7'd127, 7'd0,   1'b0));
    send_item(mk(ModeNoteOn,  1'b1, 4'd15, 7'd127, 7'd85,  1'b0));
    send_item(mk(ModeNoteOff, 1'b1, 4'd15, 7'd127, 7'd0,   1'b0));
    send_item(mk(ModeNoteOn,  1'b1, 4'd15, 7'd64,  7'd42,  1'b0));
    send_item(mk(ModeNoteOff, 1'b1, 4'd15, 7'd64,  7'd0,   1'b0));
    send_item(mk(ModeSustain, 1'b1, 4'd15, 7'd127, 7'd0,   1'b0));
    send_item(mk(ModeSustain, 1'b1, 4'd15, 7'd0,   7'd0,   1'b0));
    // Channel free picks up both active and held notes, one half at a time
    send_item(mk(ModeNoteOn,  1'b0, 4'd5,  7'd10,  7'd100, 1'b0));
    send_item(mk(ModeNoteOn,  1'b0, 4'd5,  7'd63,  7'd99,  1'b0));
    send_item(mk(ModeNoteOn,  1'b0, 4'd5,  7'd100, 7'd7,   1'b0));
    send_item(mk(ModeSustain, 1'b0, 4'd5,  7'd0,   7'd0,   1'b1));
    send_item(mk(ModeNoteOff, 1'b0, 4'd5,  7'd63,  7'd0,   1'b0));
    send_item(mk(ModeFree,    1'b0, 4'd5,  7'd0,   7'd0,   1'b0));
    send_item(mk(ModeFree,    1'b0, 4'd5,  7'd64,  7'd0,   1'b0));
    // Layers stay apart on the same channel and note
    send_item(mk(ModeNoteOn,  1'b0, 4'd10, 7'd42,  7'd85,  1'b0));
    send_item(mk(ModeNoteOn,  1'b1, 4'd10, 7'd42,  7'd21,  1'b0));
    send_item(mk(ModeFree,    1'b1, 4'd10, 7'd127, 7'd0,   1'b0));
    send_item(mk(ModeNoteOff, 1'b0, 4'd10, 7'd42,  7'd0,   1'b0));
    send_item(mk(ModeFree,    1'b0, 4'd10, 7'd0,   7'd0,   1'b0));

    // Random phases, alternating the mute gate
    for (int p = 0; p < 5; p++) begin
      write_mute(phase_mute[p]);
      refresh_pools();
      for (int n = 0; n < phase_len[p]; n++) begin
        send_calm = ((n % 40) < 10);
        send_item(random_item());
      end
    end
    send_calm = 1'b0;

    wait_idle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- midi_note_sustain_tracker_core.f -----
+incdir+sv
sv/mnst_pkg.sv
sv/mnst_ram.sv
sv/mnst_ctrl.sv
sv/mnst_dp.sv
sv/midi_note_sustain_tracker_core.sv
sv/mnst_checker.sv
test/midi_note_sustain_tracker_core_checker.sv
test/midi_note_sustain_tracker_core_test.sv
